@@ hw/rtl/cureg_pkg.sv @@
// Shared widths, word map and reset values of the clock-unit register file.
`timescale 1ns / 1ps
`default_nettype none
package cureg_pkg;

   localparam int unsigned DataWidth   = 32;
   localparam int unsigned OffsetWidth = 13;
   localparam int unsigned WordCount   = 63;
   localparam int unsigned AddrWidth   = $clog2(WordCount);

   typedef logic [DataWidth-1:0]   data_type;
   typedef logic [OffsetWidth-1:0] offset_type;
   typedef logic [AddrWidth-1:0]   addr_type;

   localparam logic ActionRead  = 1'b0;
   localparam logic ActionWrite = 1'b1;

   localparam addr_type LockBase   = AddrWidth'(0);
   localparam addr_type PllBase    = AddrWidth'(5);
   localparam addr_type SrcBase    = AddrWidth'(10);
   localparam addr_type MaskBase   = AddrWidth'(17);
   localparam addr_type DivBase    = AddrWidth'(19);
   localparam addr_type GateBase   = AddrWidth'(27);
   localparam addr_type OutputAddr = AddrWidth'(62);

   localparam data_type Src0Reset  = 32'h1000_1111;
   localparam data_type Src6Reset  = 32'h0100_0000;
   localparam data_type Div0Keep   = 32'h7F7F_7777;
   localparam data_type Low16Keep  = 32'h0000_FFFF;
   localparam data_type LockedBit  = 32'h2000_0000;

   function automatic data_type reset_word(input addr_type addr);
      data_type word;
      word = '0;
      unique case (addr)
         PllBase:                        word = 32'hA0C8_0601;
         PllBase + AddrWidth'(1):        word = 32'hA29B_0C01;
         PllBase + AddrWidth'(2):        word = 32'hA060_0602;
         PllBase + AddrWidth'(4):        word = 32'hA06C_0603;
         SrcBase:                        word = Src0Reset;
         SrcBase + AddrWidth'(4):        word = 32'h6666_6666;
         SrcBase + AddrWidth'(5):        word = 32'h0000_0777;
         SrcBase + AddrWidth'(6):        word = Src6Reset;
         DivBase:                        word = 32'h1413_1330;
         default:                        word = '0;
      endcase
      return word;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cureg_if.sv @@
// Valid/ready channel interfaces for bus accesses and their responses.
`timescale 1ns / 1ps
`default_nettype none
interface cureg_req_if
   import cureg_pkg::*;
();
   logic       valid;
   logic       ready;
   logic       action;
   offset_type offset;
   data_type   write_data;

   modport source (output valid, action, offset, write_data, input ready);
   modport sink (input valid, action, offset, write_data, output ready);
endinterface

interface cureg_rsp_if
   import cureg_pkg::*;
();
   logic     valid;
   logic     ready;
   data_type read_data;
   logic     error;

   modport source (output valid, read_data, error, input ready);
   modport sink (input valid, read_data, error, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/clock_unit_register_file.sv @@
// Clock-unit register file: decodes bus accesses and keeps the register banks.
//
// The req_chan channel carries one access per transfer: action (0 read,
// 1 write), a byte offset and write data. The rsp_chan channel returns one
// response per access: read data (0 for writes and bad offsets) and error.
// Register words live in a 63-word RAM with a registered read; the source
// select word and the bits behind the mux-status words are held in flops.
// Each RAM word has a valid bit, and a word never written reads as its
// reset value.
// A request is registered in stage 1, then in the response register. A new
// request is taken once the previous one has moved into the response
// register and that register is empty or being taken, so none is taken
// while one is in stage 1, even with ready held high. When the receiver
// stalls, the response holds and no request is taken.
// Synchronous reset clears all valid bits, restores the select word and
// status bits, and empties the pipeline; the block is ready as soon as reset
// is low.
`timescale 1ns / 1ps
`default_nettype none
module clock_unit_register_file
   import cureg_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   cureg_req_if.sink  req_chan,
   cureg_rsp_if.source rsp_chan
);
   typedef enum logic [3:0] {
      RegionLock, RegionPll, RegionSrc, RegionMask, RegionDiv, RegionGate,
      RegionOutput, RegionDivStatus, RegionMux0, RegionMux1, RegionBad
   } region_type;

   region_type region;
   offset_type off;
   data_type   wv;
   logic       accept;
   logic [2:0] idx;
   addr_type   ram_addr;
   logic       ram_wr;
   data_type   ram_wdata;
   data_type   ram_rdata;
   logic       in_ram;
   logic       ok;
   data_type   imm;
   logic [1:0] sel_pos;

   logic [WordCount-1:0] valid_ff, valid_in;
   logic [7:0] src0_ff, src0_in;
   logic [3:0] src2_ff, src2_in;
   logic [2:0] src6_ff, src6_in;

   logic     s1_valid_ff, s1_valid_in;
   logic     s1_ram_ff, s1_ram_in;
   logic     s1_vld_ff, s1_vld_in;
   addr_type s1_addr_ff, s1_addr_in;
   data_type s1_imm_ff, s1_imm_in;
   logic     s1_err_ff, s1_err_in;

   logic     rsp_valid_ff, rsp_valid_in;
   data_type rsp_data_ff, rsp_data_in;
   logic     rsp_err_ff, rsp_err_in;

   function automatic data_type spread_src0(input logic [7:0] sel);
      data_type word;
      word = '0;
      for (int k = 0; k < 8; k++) begin
         word[4*k] = sel[k];
      end
      return word;
   endfunction

   function automatic data_type mux_status0(input logic [7:0] sel);
      data_type word;
      word = '0;
      for (int k = 0; k < 8; k++) begin
         word[4*k +: 2] = sel[k] ? 2'b10 : 2'b01;
      end
      return word;
   endfunction

   function automatic data_type mux_status1(input logic [3:0] s2, input logic [2:0] s6);
      data_type word;
      word = '0;
      word[17:16] = s6[0] ? 2'b10 : 2'b01;
      word[10:8]  = {s6[2], s6[1], s6[1]};
      word[6:4]   = {s2[3], s2[2], s2[2]};
      word[2:0]   = {s2[1], s2[0], s2[0]};
      return word;
   endfunction

   assign off    = req_chan.offset;
   assign wv     = req_chan.write_data;
   assign req_chan.ready = !reset && !s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      region = RegionBad;
      idx    = '0;
      priority if (off <= 13'h020) begin
         region = RegionLock;
         idx    = off[5:3];
      end else if (off >= 13'h100 && off <= 13'h120) begin
         region = RegionPll;
         idx    = off[5:3];
      end else if (off >= 13'h200 && off <= 13'h218) begin
         region = RegionSrc;
         idx    = off[4:2];
      end else if (off >= 13'h280 && off <= 13'h284) begin
         region = RegionMask;
         idx    = {2'b00, off[2]};
      end else if (off >= 13'h300 && off <= 13'h31C) begin
         region = RegionDiv;
         idx    = off[4:2];
      end else if (off >= 13'h400 && off <= 13'h488) begin
         region = RegionGate;
      end else if (off == 13'h500) begin
         region = RegionOutput;
      end else if (off == 13'h1000 || off == 13'h1004) begin
         region = RegionDivStatus;
      end else if (off == 13'h1100) begin
         region = RegionMux0;
      end else if (off == 13'h1104) begin
         region = RegionMux1;
      end else begin
         region = RegionBad;
      end
   end

   always_comb begin
      ram_addr  = '0;
      in_ram    = 1'b0;
      ok        = 1'b1;
      imm       = '0;
      ram_wr    = 1'b0;
      ram_wdata = wv;
      src0_in   = src0_ff;
      src2_in   = src2_ff;
      src6_in   = src6_ff;
      sel_pos   = (idx == 3'd4) ? 2'd3 : idx[1:0];
      unique case (region)
         RegionLock:   ram_addr = LockBase + AddrWidth'(idx);
         RegionPll:    ram_addr = PllBase + AddrWidth'(idx);
         RegionSrc:    ram_addr = SrcBase + AddrWidth'(idx);
         RegionMask:   ram_addr = MaskBase + AddrWidth'(idx);
         RegionDiv:    ram_addr = DivBase + AddrWidth'(idx);
         RegionGate:   ram_addr = GateBase + AddrWidth'(off[7:2]);
         RegionOutput: ram_addr = OutputAddr;
         default:      ram_addr = '0;
      endcase
      if (req_chan.action == ActionRead) begin
         unique case (region)
            RegionLock, RegionPll, RegionMask, RegionDiv, RegionGate,
            RegionOutput: in_ram = 1'b1;
            RegionSrc: begin
               if (idx == 3'd0) begin
                  imm = spread_src0(src0_ff);
               end else begin
                  in_ram = 1'b1;
               end
            end
            RegionDivStatus: imm = '0;
            RegionMux0:      imm = mux_status0(src0_ff);
            RegionMux1:      imm = mux_status1(src2_ff, src6_ff);
            RegionBad:       ok = 1'b0;
            default:         ok = 1'b0;
         endcase
      end else begin
         unique case (region)
            RegionLock, RegionMask, RegionGate, RegionOutput: ram_wr = 1'b1;
            RegionPll: begin
               ram_wr    = 1'b1;
               ram_wdata = wv | LockedBit;
               if (idx == 3'd3) begin
                  ok = 1'b0;
               end else begin
                  src0_in[sel_pos] = wv[31];
               end
            end
            RegionSrc: begin
               if (idx == 3'd0) begin
                  for (int k = 0; k < 8; k++) begin
                     src0_in[k] = wv[4*k];
                  end
               end else begin
                  ram_wr = 1'b1;
                  if (idx == 3'd5) begin
                     ram_wdata = wv & Low16Keep;
                  end
                  if (idx == 3'd2) begin
                     src2_in = {wv[5], wv[4], wv[1], wv[0]};
                  end
                  if (idx == 3'd6) begin
                     src6_in = {wv[25], wv[24], wv[16]};
                  end
               end
            end
            RegionDiv: begin
               ram_wr = 1'b1;
               if (idx == 3'd0) begin
                  ram_wdata = wv & Div0Keep;
               end else if (idx == 3'd5) begin
                  ram_wdata = wv & Low16Keep;
               end
            end
            RegionDivStatus, RegionMux0, RegionMux1, RegionBad: ok = 1'b0;
            default: ok = 1'b0;
         endcase
      end
   end

   cureg_ram #(
      .Width(DataWidth),
      .Depth(WordCount)
   ) u_ram (
      .clock  (clock),
      .wr_en  (accept && ram_wr),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   always_comb begin
      valid_in = valid_ff;
      if (accept && ram_wr) begin
         valid_in[ram_addr] = 1'b1;
      end
      s1_valid_in = accept;
      s1_ram_in   = in_ram;
      s1_vld_in   = valid_ff[ram_addr];
      s1_addr_in  = ram_addr;
      s1_imm_in   = imm;
      s1_err_in   = !ok;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      if (s1_valid_ff) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = s1_err_ff;
         if (s1_ram_ff) begin
            rsp_data_in = s1_vld_ff ? ram_rdata : reset_word(s1_addr_ff);
         end else begin
            rsp_data_in = s1_imm_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         src0_ff      <= 8'b1000_1111;
         src2_ff      <= '0;
         src6_ff      <= 3'b010;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            src0_ff <= src0_in;
            src2_ff <= src2_in;
            src6_ff <= src6_in;
         end
      end
      if (accept) begin
         s1_ram_ff  <= s1_ram_in;
         s1_vld_ff  <= s1_vld_in;
         s1_addr_ff <= s1_addr_in;
         s1_imm_ff  <= s1_imm_in;
         s1_err_ff  <= s1_err_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.error     = rsp_err_ff;
endmodule
`default_nettype wire

@@ hw/rtl/cureg_ram.sv @@
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module cureg_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Testbench for the clock-unit register file: directed and random accesses against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import cureg_pkg::*;

   localparam int unsigned LockLast     = 32'h020;
   localparam int unsigned PllFirst     = 32'h100;
   localparam int unsigned PllLast      = 32'h120;
   localparam int unsigned SrcFirst     = 32'h200;
   localparam int unsigned SrcLast      = 32'h218;
   localparam int unsigned MaskFirst    = 32'h280;
   localparam int unsigned MaskLast     = 32'h284;
   localparam int unsigned DivFirst     = 32'h300;
   localparam int unsigned DivLast      = 32'h31C;
   localparam int unsigned GateFirst    = 32'h400;
   localparam int unsigned GateLast     = 32'h488;
   localparam int unsigned ClkOutOffset = 32'h500;
   localparam int unsigned DivStatus0   = 32'h1000;
   localparam int unsigned DivStatus1   = 32'h1004;
   localparam int unsigned MuxStatus0   = 32'h1100;
   localparam int unsigned MuxStatus1   = 32'h1104;
   localparam int unsigned OffsetTop    = 4367;
   localparam int unsigned PllNoLock    = 3;
   localparam int unsigned PllLastSel   = 4;
   localparam data_type    SrcSelKeep   = 32'h1111_1111;
   localparam int unsigned RandomCount  = 750;
   localparam int unsigned CycleLimit   = 200000;

   typedef struct packed {
      logic       action;
      offset_type offset;
      data_type   write_data;
      logic       pinned;
      data_type   pinned_data;
      logic       pinned_error;
   } access_type;

   typedef struct packed {
      data_type read_data;
      logic     error;
   } result_type;

   logic clock;
   logic reset;

   cureg_req_if req_chan ();
   cureg_rsp_if rsp_chan ();

   clock_unit_register_file DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   data_type lock_words [5];
   data_type pll_words [5];
   data_type src_words [7];
   data_type mask_words [2];
   data_type div_words [8];
   data_type gate_words [35];
   data_type clk_out_word;

   result_type  pending_results [$];
   access_type  directed_rows [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_mode = 0;
   int unsigned burst_left = 0;
   int unsigned read_count = 0;
   int unsigned write_count = 0;
   int unsigned error_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic access_type directed_row(input logic action, input int unsigned offset,
                                               input data_type write_data, input logic pinned,
                                               input data_type pinned_data,
                                               input logic pinned_error);
      access_type row;
      row.action       = action;
      row.offset       = offset_type'(offset);
      row.write_data   = write_data;
      row.pinned       = pinned;
      row.pinned_data  = pinned_data;
      row.pinned_error = pinned_error;
      return row;
   endfunction

   // Applies one access to the predicted register state and returns the expected response.
   function automatic result_type apply_access(input access_type a);
      result_type  r;
      int unsigned off;
      int unsigned idx;
      int unsigned sel;
      logic        hit;
      data_type    s2;
      data_type    s6;
      r.read_data = '0;
      r.error     = 1'b0;
      hit = 1'b1;
      off = a.offset;
      if (a.action == ActionWrite) begin
         if (off <= LockLast) begin
            lock_words[off >> 3] = a.write_data;
         end else if (off >= PllFirst && off <= PllLast) begin
            idx = (off - PllFirst) >> 3;
            pll_words[idx] = a.write_data | LockedBit;
            if (idx == PllNoLock) begin
               hit = 1'b0;
            end else begin
               sel = (idx == PllLastSel) ? 12 : idx * 4;
               src_words[0][sel] = a.write_data[31];
            end
         end else if (off >= SrcFirst && off <= SrcLast) begin
            src_words[(off - SrcFirst) >> 2] = a.write_data;
            src_words[0] &= SrcSelKeep;
            src_words[5] &= Low16Keep;
         end else if (off >= MaskFirst && off <= MaskLast) begin
            mask_words[(off - MaskFirst) >> 2] = a.write_data;
         end else if (off >= DivFirst && off <= DivLast) begin
            div_words[(off - DivFirst) >> 2] = a.write_data;
            div_words[0] &= Div0Keep;
            div_words[5] &= Low16Keep;
         end else if (off >= GateFirst && off <= GateLast) begin
            gate_words[(off - GateFirst) >> 2] = a.write_data;
         end else if (off == ClkOutOffset) begin
            clk_out_word = a.write_data;
         end else begin
            hit = 1'b0;
         end
      end else begin
         if (off <= LockLast) begin
            r.read_data = lock_words[off >> 3];
         end else if (off >= PllFirst && off <= PllLast) begin
            r.read_data = pll_words[(off - PllFirst) >> 3];
         end else if (off >= SrcFirst && off <= SrcLast) begin
            r.read_data = src_words[(off - SrcFirst) >> 2];
         end else if (off >= MaskFirst && off <= MaskLast) begin
            r.read_data = mask_words[(off - MaskFirst) >> 2];
         end else if (off >= DivFirst && off <= DivLast) begin
            r.read_data = div_words[(off - DivFirst) >> 2];
         end else if (off >= GateFirst && off <= GateLast) begin
            r.read_data = gate_words[(off - GateFirst) >> 2];
         end else if (off == ClkOutOffset) begin
            r.read_data = clk_out_word;
         end else if (off == DivStatus0 || off == DivStatus1) begin
            r.read_data = '0;
         end else if (off == MuxStatus0) begin
            for (int i = 0; i < 8; i++) begin
               r.read_data[4*i +: 4] = src_words[0][4*i] ? 4'd2 : 4'd1;
            end
         end else if (off == MuxStatus1) begin
            s2 = src_words[2];
            s6 = src_words[6];
            r.read_data[17:16] = s6[16] ? 2'd2 : 2'd1;
            r.read_data[10:8]  = {s6[25], s6[24], s6[24]};
            r.read_data[6:4]   = {s2[5], s2[4], s2[4]};
            r.read_data[2:0]   = {s2[1], s2[0], s2[0]};
         end else begin
            hit = 1'b0;
         end
      end
      if (!hit) begin
         r.read_data = '0;
         r.error     = 1'b1;
      end
      return r;
   endfunction

   // Presents one access, holds it until the transfer, and queues its expected response.
   task automatic transfer_access(input access_type a);
      result_type want;
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.action     <= a.action;
      req_chan.offset     <= a.offset;
      req_chan.write_data <= a.write_data;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      want = apply_access(a);
      if (a.pinned) begin
         want.read_data = a.pinned_data;
         want.error     = a.pinned_error;
      end
      pending_results.push_back(want);
      if (a.action == ActionWrite) write_count++;
      else read_count++;
      if (want.error) error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 128 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_chan.ready <= (cycle_count % 8) >= 3;
      endcase
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("Response transfer with no access outstanding");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.read_data !== want.read_data) begin
               $error("read_data mismatch: expected %h, actual %h", want.read_data,
                      rsp_chan.read_data);
               mismatch_count++;
            end
            if (rsp_chan.error !== want.error) begin
               $error("error mismatch: expected %b, actual %b", want.error, rsp_chan.error);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      access_type  a;
      int unsigned off;
      int unsigned pick;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= ActionRead;
      req_chan.offset     <= '0;
      req_chan.write_data <= '0;

      foreach (lock_words[i]) lock_words[i] = '0;
      pll_words = '{32'hA0C8_0601, 32'hA29B_0C01, 32'hA060_0602, 32'h0, 32'hA06C_0603};
      src_words = '{Src0Reset, 32'h0, 32'h0, 32'h0, 32'h6666_6666, 32'h0000_0777, Src6Reset};
      foreach (mask_words[i]) mask_words[i] = '0;
      foreach (div_words[i]) div_words[i] = '0;
      div_words[0] = 32'h1413_1330;
      foreach (gate_words[i]) gate_words[i] = '0;
      clk_out_word = '0;

      directed_rows.push_back(directed_row(ActionRead, 32'h100, 0, 1, 32'hA0C8_0601, 0));
      directed_rows.push_back(directed_row(ActionRead, 32'h11F, 0, 1, 32'h0, 0));
      directed_rows.push_back(directed_row(ActionRead, 32'h31C, 0, 1, 32'h0, 0));
      directed_rows.push_back(directed_row(ActionRead, 32'h218, 0, 1, Src6Reset, 0));
      directed_rows.push_back(directed_row(ActionRead, MuxStatus0, 0, 0, 0, 0));
      directed_rows.push_back(directed_row(ActionRead, MuxStatus1, 0, 0, 0, 0));
      directed_rows.push_back(directed_row(ActionRead, DivStatus0, 0, 1, 32'h0, 0));
      directed_rows.push_back(directed_row(ActionRead, DivStatus1, 0, 1, 32'h0, 0));
      directed_rows.push_back(directed_row(ActionWrite, MuxStatus1, '1, 1, 32'h0, 1));
      directed_rows.push_back(directed_row(ActionRead, 32'h0FFF, 0, 1, 32'h0, 1));
      directed_rows.push_back(directed_row(ActionRead, OffsetTop, 0, 1, 32'h0, 1));
      directed_rows.push_back(directed_row(ActionWrite, 32'h000, '1, 1, 32'h0, 0));
      directed_rows.push_back(directed_row(ActionRead, 32'h007, 0, 1, 32'hFFFF_FFFF, 0));
      directed_rows.push_back(directed_row(ActionWrite, 32'h118, 0, 1, 32'h0, 1));
      directed_rows.push_back(directed_row(ActionRead, 32'h118, 0, 1, LockedBit, 0));
      directed_rows.push_back(directed_row(ActionWrite, 32'h100, 32'h8000_0000, 1, 32'h0, 0));
      directed_rows.push_back(directed_row(ActionWrite, 32'h120, 0, 1, 32'h0, 0));
      directed_rows.push_back(directed_row(ActionRead, 32'h200, 0, 0, 0, 0));
      directed_rows.push_back(directed_row(ActionWrite, 32'h200, '1, 1, 32'h0, 0));
      directed_rows.push_back(directed_row(ActionRead, MuxStatus0, 0, 0, 0, 0));
      directed_rows.push_back(directed_row(ActionWrite, 32'h214, '1, 1, 32'h0, 0));
      directed_rows.push_back(directed_row(ActionRead, 32'h217, 0, 1, Low16Keep, 0));
      directed_rows.push_back(directed_row(ActionWrite, 32'h300, '1, 1, 32'h0, 0));
      directed_rows.push_back(directed_row(ActionRead, 32'h303, 0, 1, Div0Keep, 0));
      directed_rows.push_back(directed_row(ActionWrite, 32'h488, 32'hA5A5_A5A5, 1, 32'h0, 0));
      directed_rows.push_back(directed_row(ActionRead, 32'h488, 0, 1, 32'hA5A5_A5A5, 0));
      directed_rows.push_back(directed_row(ActionWrite, 32'h501, 0, 1, 32'h0, 1));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) transfer_access(directed_rows[i]);

      for (int n = 0; n < RandomCount; n++) begin
         a.action     = $urandom_range(0, 1) ? ActionWrite : ActionRead;
         a.write_data = $urandom;
         pick = $urandom_range(0, 7);
         if (pick == 0) a.write_data = '0;
         else if (pick == 1) a.write_data = '1;
         case ($urandom_range(0, 11))
            0: off = $urandom_range(0, LockLast);
            1, 2: off = $urandom_range(PllFirst, PllLast);
            3, 4: off = $urandom_range(SrcFirst, SrcLast);
            5: off = $urandom_range(MaskFirst, MaskLast);
            6: off = $urandom_range(DivFirst, DivLast);
            7: off = $urandom_range(GateFirst, GateLast);
            8: off = ClkOutOffset;
            9: begin
               case ($urandom_range(0, 3))
                  0: off = DivStatus0;
                  1: off = DivStatus1;
                  2: off = MuxStatus0;
                  default: off = MuxStatus1;
               endcase
            end
            10: off = $urandom_range(0, OffsetTop);
            default: begin
               case ($urandom_range(0, 12))
                  0: off = LockLast + 1;
                  1: off = PllFirst - 1;
                  2: off = PllLast + 1;
                  3: off = SrcFirst - 1;
                  4: off = SrcLast + 1;
                  5: off = MaskFirst - 1;
                  6: off = MaskLast + 1;
                  7: off = DivLast + 1;
                  8: off = GateLast + 1;
                  9: off = ClkOutOffset + 1;
                  10: off = DivStatus0 + 2;
                  11: off = MuxStatus1 + 4;
                  default: off = MuxStatus0 - 1;
               endcase
            end
         endcase
         a.offset       = offset_type'(off);
         a.pinned       = 1'b0;
         a.pinned_data  = '0;
         a.pinned_error = 1'b0;
         transfer_access(a);
      end

      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Checked %0d accesses: %0d reads and %0d writes, %0d answered with error.",
               read_count + write_count, read_count, write_count, error_count);
      $display("Covered every bank, the status words, near-miss offsets and receiver stalls.");
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
